/* sv/cds_pkg.sv */
// Shared types, sizes and command codes for the checked data stack.
package cds_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int WORD_W      = 64;
	localparam int CMD_W       = 4;
	localparam int FIELD_W     = 9;
	localparam int STATUS_W    = 2;
	localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W       = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [FIELD_W-1:0]  field_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [CMP_W-1:0]    cmp_t;

	localparam cmd_t CMD_PUSH        = 4'd0;
	localparam cmd_t CMD_POP         = 4'd1;
	localparam cmd_t CMD_POP_ZERO    = 4'd2;
	localparam cmd_t CMD_POP_OR_TOP  = 4'd3;
	localparam cmd_t CMD_DUP         = 4'd4;
	localparam cmd_t CMD_DROP        = 4'd5;
	localparam cmd_t CMD_DROP_N      = 4'd6;
	localparam cmd_t CMD_PICK        = 4'd7;
	localparam cmd_t CMD_PICK_BOTTOM = 4'd8;
	localparam cmd_t CMD_SET_TOP     = 4'd9;
	localparam cmd_t CMD_SET_BOTTOM  = 4'd10;
	localparam cmd_t CMD_PEEK        = 4'd11;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_OVER  = 2'd1;
	localparam status_t ST_UNDER = 2'd2;

endpackage

/* sv/checked_data_stack.sv */
// Top level of the checked data stack: decode, entry memory and result register.
// Result path: an accepted command passes the stage-one registers, then the result
// register; its beat has done high for exactly one cycle and cannot be stalled.
// Throughput: one command per cycle, so busy is never raised. The figure is set by
// the single write port of the entry memory, written in the cycle after acceptance.
// Reset clears the element count and the pipeline valid flags at once. The entry
// memory is not cleared: only entries below the count are ever read.
module checked_data_stack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cds_pkg::cmd_t     command,
	input  cds_pkg::word_t    value,
	input  cds_pkg::field_t   offset,
	output logic              done,
	output cds_pkg::word_t    read_value,
	output cds_pkg::field_t   depth_now,
	output cds_pkg::status_t  status
);
	import cds_pkg::*;

	// Architectural element count.
	cnt_t    fill_q;

	// Decode results for the command being accepted.
	logic    accept;
	cnt_t    fill_nxt;
	status_t st_d;
	logic    rd_mem_d;
	logic    rd_val_d;
	logic    we_d;
	logic    wsel_mem_d;
	addr_t   raddr_d;
	addr_t   waddr_d;
	cmp_t    n_c;
	cmp_t    off_c;
	cmp_t    pick_c;
	cmp_t    drop_c;
	cmp_t    new_c;
	addr_t   top_addr;
	logic    empty;
	logic    full;

	// Stage one: memory read data arrives here, writes are committed here.
	logic    valid_s1;
	logic    rd_mem_s1;
	logic    rd_val_s1;
	logic    we_s1;
	logic    wsel_mem_s1;
	addr_t   raddr_s1;
	addr_t   waddr_s1;
	word_t   value_s1;
	field_t  depth_s1;
	status_t status_s1;
	word_t   rdata_s1;

	// The write committed at the last edge, which the memory read missed.
	logic    byp_valid_q;
	addr_t   byp_addr_q;
	word_t   byp_data_q;

	word_t   mem_word;
	word_t   rd_word;
	word_t   wdata;
	logic    wr_en;

	// Result register.
	logic    done_q;
	word_t   read_value_q;
	field_t  depth_q;
	status_t status_q;

	word_t   entry_mem [MAX_ENTRIES];

	// Every command finishes in one pass, so the block never holds off a start.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign empty    = (fill_q == '0);
	assign full     = (fill_q == cnt_t'(MAX_ENTRIES));
	assign top_addr = addr_t'(fill_q - cnt_t'(1));
	assign n_c      = cmp_t'(fill_q);
	assign off_c    = cmp_t'(offset);
	assign pick_c   = n_c - cmp_t'(1) - off_c;
	assign drop_c   = n_c - off_c;
	assign new_c    = cmp_t'(fill_nxt);

	// Checks are made against the count before the command; a refused command
	// leaves the count and the memory untouched.
	always_comb begin
		fill_nxt   = fill_q;
		st_d       = ST_OK;
		rd_mem_d   = 1'b0;
		rd_val_d   = 1'b0;
		we_d       = 1'b0;
		wsel_mem_d = 1'b0;
		raddr_d    = top_addr;
		waddr_d    = fill_q[ADDR_W-1:0];
		unique case (command)
			CMD_PUSH: begin
				if (full) begin
					st_d = ST_OVER;
				end else begin
					we_d     = 1'b1;
					rd_val_d = 1'b1;
					fill_nxt = fill_q + cnt_t'(1);
				end
			end
			CMD_POP, CMD_POP_ZERO: begin
				if (empty) begin
					st_d = (command == CMD_POP) ? ST_UNDER : ST_OK;
				end else begin
					rd_mem_d = 1'b1;
					fill_nxt = fill_q - cnt_t'(1);
				end
			end
			CMD_POP_OR_TOP: begin
				if (empty) begin
					st_d = ST_UNDER;
				end else begin
					rd_mem_d = 1'b1;
					if (fill_q != cnt_t'(1)) begin
						fill_nxt = fill_q - cnt_t'(1);
					end
				end
			end
			CMD_DUP: begin
				if (empty) begin
					st_d = ST_UNDER;
				end else if (full) begin
					st_d = ST_OVER;
				end else begin
					rd_mem_d   = 1'b1;
					we_d       = 1'b1;
					wsel_mem_d = 1'b1;
					fill_nxt   = fill_q + cnt_t'(1);
				end
			end
			CMD_DROP: begin
				if (empty) begin
					st_d = ST_UNDER;
				end else begin
					fill_nxt = fill_q - cnt_t'(1);
				end
			end
			CMD_DROP_N: begin
				if (off_c > n_c) begin
					st_d = ST_UNDER;
				end else begin
					fill_nxt = drop_c[CNT_W-1:0];
				end
			end
			CMD_PICK: begin
				if (off_c >= n_c) begin
					st_d = ST_UNDER;
				end else begin
					rd_mem_d = 1'b1;
					raddr_d  = pick_c[ADDR_W-1:0];
				end
			end
			CMD_PICK_BOTTOM: begin
				if (off_c >= n_c) begin
					st_d = ST_UNDER;
				end else begin
					rd_mem_d = 1'b1;
					raddr_d  = off_c[ADDR_W-1:0];
				end
			end
			CMD_SET_TOP: begin
				if (empty) begin
					st_d = ST_UNDER;
				end else begin
					we_d    = 1'b1;
					waddr_d = top_addr;
				end
			end
			CMD_SET_BOTTOM: begin
				if (empty) begin
					st_d = ST_UNDER;
				end else begin
					we_d    = 1'b1;
					waddr_d = '0;
				end
			end
			CMD_PEEK: begin
				if (empty) begin
					st_d = ST_UNDER;
				end else begin
					rd_mem_d = 1'b1;
				end
			end
			default: begin
				// Unused codes are ignored and report a clean status.
			end
		endcase
	end

	// The count moves at acceptance, so the next command can be checked at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			valid_s1    <= 1'b0;
			byp_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_nxt;
			end
			valid_s1    <= accept;
			byp_valid_q <= wr_en;
			done_q      <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_mem_s1   <= rd_mem_d;
			rd_val_s1   <= rd_val_d;
			we_s1       <= we_d;
			wsel_mem_s1 <= wsel_mem_d;
			raddr_s1    <= raddr_d;
			waddr_s1    <= waddr_d;
			value_s1    <= value;
			depth_s1    <= new_c[FIELD_W-1:0];
			status_s1   <= st_d;
		end
	end

	// Entry memory: one registered read at acceptance, one write in the cycle after.
	// The read returns the old word when it meets that write at the same edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_s1 <= entry_mem[raddr_d];
		end
		if (wr_en) begin
			entry_mem[waddr_s1] <= wdata;
		end
	end

	// A write from the previous command may have landed at the edge on which
	// this command's read was taken; forward it in that case.
	assign mem_word = (byp_valid_q && (byp_addr_q == raddr_s1)) ? byp_data_q : rdata_s1;
	assign rd_word  = rd_mem_s1 ? mem_word : (rd_val_s1 ? value_s1 : '0);
	assign wdata    = wsel_mem_s1 ? mem_word : value_s1;
	assign wr_en    = valid_s1 && we_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byp_addr_q <= waddr_s1;
			byp_data_q <= wdata;
		end
		if (valid_s1) begin
			read_value_q <= rd_word;
			depth_q      <= depth_s1;
			status_q     <= status_s1;
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;
	assign depth_now  = depth_q;
	assign status     = status_q;

`ifndef SYNTHESIS
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result beat without an accepted command two cycles before");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cnt_t'(MAX_ENTRIES))
		else $error("element count beyond stack depth");

	a_write_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (cmp_t'(waddr_s1) < cmp_t'(depth_s1)) || (depth_s1 == '0))
		else $error("entry written at or above the new count");

	a_over_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_OVER)) |-> (read_value == '0))
		else $error("overflow beat carries a data word");

	a_refused_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (st_d != ST_OK)) |=> (fill_q == $past(fill_q)))
		else $error("refused command changed the element count");
`endif

endmodule

/* sim/tb_checked_data_stack.sv */
// Self-checking testbench for the checked data stack, with a mirror of the stack as scoreboard.
`timescale 1ns / 100ps

module tb_checked_data_stack;
	import cds_pkg::*;

	// One expected result beat: the word read, the depth left behind and the status.
	typedef struct {
		word_t   rd;
		field_t  depth;
		status_t st;
	} reply_t;

	// The scoreboard keeps its own copy of the stack. Every accepted command is applied to
	// that copy at once, and the reply it should give joins a queue. Result beats from the
	// block are then matched in order against that queue.
	class stack_mirror;
		word_t  cells [MAX_ENTRIES];
		int     fill;
		reply_t replies [$];
		int     mismatches;

		function new();
			fill       = 0;
			mismatches = 0;
		endfunction

		// Applies one accepted command to the mirror and queues the reply it must give.
		function void note_command(cmd_t cmd, word_t val, field_t off);
			reply_t r;
			int     n;
			int     k;
			n    = fill;
			k    = int'(off);
			r.rd = '0;
			r.st = ST_OK;
			case (cmd)
				CMD_PUSH: begin
					if (n >= MAX_ENTRIES) begin
						r.st = ST_OVER;
					end else begin
						cells[n] = val;
						fill     = n + 1;
						r.rd     = val;
					end
				end
				CMD_POP, CMD_POP_ZERO: begin
					// An empty pop_zero is not an error: it simply reads zero.
					if (n == 0) begin
						r.st = (cmd == CMD_POP) ? ST_UNDER : ST_OK;
					end else begin
						r.rd = cells[n-1];
						fill = n - 1;
					end
				end
				CMD_POP_OR_TOP: begin
					// The last remaining element is read but kept.
					if (n == 0) begin
						r.st = ST_UNDER;
					end else begin
						r.rd = cells[n-1];
						if (n > 1)
							fill = n - 1;
					end
				end
				CMD_DUP: begin
					if (n == 0) begin
						r.st = ST_UNDER;
					end else if (n >= MAX_ENTRIES) begin
						r.st = ST_OVER;
					end else begin
						r.rd     = cells[n-1];
						cells[n] = cells[n-1];
						fill     = n + 1;
					end
				end
				CMD_DROP: begin
					if (n == 0)
						r.st = ST_UNDER;
					else
						fill = n - 1;
				end
				CMD_DROP_N: begin
					if (k > n)
						r.st = ST_UNDER;
					else
						fill = n - k;
				end
				CMD_PICK: begin
					if (k >= n)
						r.st = ST_UNDER;
					else
						r.rd = cells[n-1-k];
				end
				CMD_PICK_BOTTOM: begin
					if (k >= n)
						r.st = ST_UNDER;
					else
						r.rd = cells[k];
				end
				CMD_SET_TOP: begin
					if (n == 0)
						r.st = ST_UNDER;
					else
						cells[n-1] = val;
				end
				CMD_SET_BOTTOM: begin
					if (n == 0)
						r.st = ST_UNDER;
					else
						cells[0] = val;
				end
				CMD_PEEK: begin
					if (n == 0)
						r.st = ST_UNDER;
					else
						r.rd = cells[n-1];
				end
				default: begin
				end
			endcase
			r.depth = field_t'(fill);
			replies.push_back(r);
		endfunction

		// Compares one result beat, field by field, with the oldest queued reply.
		function void check_reply(word_t rd, field_t depth, status_t st);
			reply_t r;
			if (replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with none expected: read %h depth %0d status %0d",
						$time, rd, depth, st);
				return;
			end
			r = replies.pop_front();
			if (rd !== r.rd || depth !== r.depth || st !== r.st) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: read %h/%h depth %0d/%0d status %0d/%0d (exp/act)",
						$time, r.rd, rd, r.depth, depth, r.st, st);
			end
		endfunction
	endclass

	logic    clk        = 1'b0;
	logic    arst_n     = 1'b0;
	logic    start      = 1'b0;
	cmd_t    command    = CMD_PUSH;
	word_t   value      = '0;
	field_t  offset     = '0;
	logic    busy;
	logic    done;
	word_t   read_value;
	field_t  depth_now;
	status_t status;

	stack_mirror mirror;
	int          idle_pct;

	checked_data_stack dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.value      (value),
		.offset     (offset),
		.done       (done),
		.read_value (read_value),
		.depth_now  (depth_now),
		.status     (status)
	);

	always #4 clk = ~clk;

	// The receiver cannot hold results off, so every beat with done high is taken as it comes.
	// Sampling at the rising edge sees the values of the cycle that the edge ends.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1 && mirror != null)
			mirror.check_reply(read_value, depth_now, status);
	end

	// Offers one command beat and returns once the block has taken it. Before the offer the
	// sender may sit idle for a while, with random junk on the payload ports meanwhile.
	task automatic send_command(input cmd_t c, input word_t v, input field_t o);
		while ($urandom_range(99) < idle_pct) begin
			start   <= 1'b0;
			command <= cmd_t'($urandom_range(15));
			value   <= {$urandom, $urandom};
			offset  <= field_t'($urandom_range(511));
			@(posedge clk);
		end
		start   <= 1'b1;
		command <= c;
		value   <= v;
		offset  <= o;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		mirror.note_command(c, v, o);
	endtask

	// Data words: mostly fully random, with the signed extremes, all ones and zero now and then.
	function automatic word_t choose_value();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return 64'h7FFF_FFFF_FFFF_FFFF;
		else if (r < 6)
			return 64'h8000_0000_0000_0000;
		else if (r < 8)
			return '1;
		else if (r < 10)
			return '0;
		return {$urandom, $urandom};
	endfunction

	// Commands lean towards the target depth: growth below it, shrinkage above it, and a
	// share of any command at all so that reads and overwrites stay frequent.
	function automatic cmd_t choose_command(int f, int target);
		int r;
		r = $urandom_range(99);
		if (f < target && r < 70) begin
			return ($urandom_range(3) == 0) ? CMD_DUP : CMD_PUSH;
		end else if (f > target && r < 70) begin
			case ($urandom_range(4))
				0:       return CMD_POP;
				1:       return CMD_POP_ZERO;
				2:       return CMD_POP_OR_TOP;
				3:       return CMD_DROP;
				default: return CMD_DROP_N;
			endcase
		end
		return cmd_t'($urandom_range(11));
	endfunction

	// Offsets are mostly in range, often exactly on the depth (the first out-of-range pick,
	// or a drop_n that empties the stack), and otherwise anywhere up to the stack's capacity.
	function automatic field_t choose_offset(cmd_t c, int f, int target);
		int r;
		int span;
		r = $urandom_range(99);
		if (c == CMD_DROP_N && f > target && r < 60) begin
			span = f - target;
			if (span > 12)
				span = 12;
			return field_t'($urandom_range(span));
		end
		if (r < 70) begin
			if (f == 0)
				return '0;
			return (c == CMD_DROP_N) ? field_t'($urandom_range(f)) : field_t'($urandom_range(f - 1));
		end else if (r < 85) begin
			return field_t'(f);
		end
		return field_t'($urandom_range(MAX_ENTRIES));
	endfunction

	// One phase of random traffic. It is split into walks, each of which steers the depth
	// towards a target (empty and full among them) and then lingers there for a few beats,
	// pressing against the limit so that overflow and underflow are hit from both sides.
	task automatic random_phase(input int quota);
		int   issued;
		int   target;
		int   steer;
		int   linger;
		int   r;
		cmd_t c;
		issued = 0;
		while (issued < quota) begin
			r = $urandom_range(99);
			if (r < 25)
				target = MAX_ENTRIES;
			else if (r < 45)
				target = 0;
			else
				target = $urandom_range(1, MAX_ENTRIES - 1);
			while (mirror.fill != target && issued < quota) begin
				c = choose_command(mirror.fill, target);
				send_command(c, choose_value(), choose_offset(c, mirror.fill, target));
				issued++;
			end
			// At the extremes the steering points past the limit on purpose.
			if (target == MAX_ENTRIES)
				steer = MAX_ENTRIES + 1;
			else if (target == 0)
				steer = -1;
			else
				steer = target;
			linger = $urandom_range(3, 8);
			while (linger > 0 && issued < quota) begin
				c = choose_command(mirror.fill, steer);
				send_command(c, choose_value(), choose_offset(c, mirror.fill, steer));
				issued++;
				linger--;
			end
		end
	endtask

	initial begin
		mirror   = new();
		idle_pct = 38;

		// Reset is held from time zero and released on a rising edge, once only.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats on an empty stack: every command that needs an element is refused,
		// while pop_zero and a drop of zero elements both succeed.
		send_command(CMD_POP,         '0, '0);
		send_command(CMD_POP_ZERO,    '0, '0);
		send_command(CMD_POP_OR_TOP,  '0, '0);
		send_command(CMD_DUP,         '0, '0);
		send_command(CMD_DROP,        '0, '0);
		send_command(CMD_PEEK,        '0, '0);
		send_command(CMD_SET_TOP,     '1, '0);
		send_command(CMD_SET_BOTTOM,  '1, '0);
		send_command(CMD_PICK,        '0, '0);
		send_command(CMD_PICK_BOTTOM, '0, '0);
		send_command(CMD_DROP_N,      '0, 9'd0);
		send_command(CMD_DROP_N,      '0, 9'd1);

		// The signed extremes go in, then pop_or_top first pops and then keeps the last one.
		send_command(CMD_PUSH,        64'h7FFF_FFFF_FFFF_FFFF, '0);
		send_command(CMD_PUSH,        64'h8000_0000_0000_0000, '0);
		send_command(CMD_POP_OR_TOP,  '0, '0);
		send_command(CMD_POP_OR_TOP,  '0, '0);
		send_command(CMD_DUP,         '0, '0);
		send_command(CMD_SET_TOP,     '1, '0);
		send_command(CMD_SET_BOTTOM,  '0, '0);

		// Picks from both ends, up to the first offset that lies beyond the depth and an offset
		// equal to the stack's capacity; a peek and a drop of both elements close the block.
		send_command(CMD_PICK,        '0, 9'd1);
		send_command(CMD_PICK,        '0, 9'd2);
		send_command(CMD_PICK_BOTTOM, '0, 9'd1);
		send_command(CMD_PICK_BOTTOM, '0, 9'd256);
		send_command(CMD_PEEK,        '0, '0);
		send_command(CMD_DROP_N,      '0, 9'd2);

		// Random traffic in three phases: the sender idles often, then more often, then never.
		random_phase(610);
		idle_pct = 50;
		random_phase(610);
		idle_pct = 0;
		random_phase(605);

		start <= 1'b0;
		while (mirror.replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mirror.mismatches == 0 && mirror.replies.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this time.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
sv/cds_pkg.sv
sv/checked_data_stack.sv
sim/tb_checked_data_stack.sv
